>>> rtl/core/mfcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcs_pkg: shared types and constants of the filled circle span generator
// Request payload type, radius limit, span budget and queue sizing.
// ----------------------------------------------------------------------------
package mfcs_pkg;

	// field widths
	localparam int COORD_W = 10;
	localparam int RAD_W   = 5;
	localparam int COLOR_W = 16;
	localparam int SPAN_W  = 12;
	localparam int TERM_W  = 10;

	// largest radius walked; larger requests saturate here
	localparam logic [RAD_W-1:0] MAX_RADIUS = 5'd20;

	// span budget per circle and spans produced by one walk step
	localparam int MAX_SPANS      = 64;
	localparam int SPANS_PER_STEP = 4;
	localparam int CNT_W          = 7;

	// request queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// classified circle request
	typedef struct packed {
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic [RAD_W-1:0]   radius;
		logic [COLOR_W-1:0] color;
	} circle_req_t;

endpackage

>>> rtl/core/mfcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcs_if: request and span channels
// Valid/ready channels carrying one circle request and one fill span.
// ----------------------------------------------------------------------------
interface mfcs_req_if;
	logic        valid;
	logic        ready;
	logic [9:0]  center_x;
	logic [9:0]  center_y;
	logic [4:0]  radius;
	logic [15:0] color;

	modport source (output valid, center_x, center_y, radius, color, input ready);
	modport sink   (input valid, center_x, center_y, radius, color, output ready);
endinterface

interface mfcs_span_if;
	logic               valid;
	logic               ready;
	logic signed [11:0] row;
	logic signed [11:0] x_start;
	logic signed [11:0] x_end;
	logic [15:0]        span_color;
	logic               last_span;

	modport source (output valid, row, x_start, x_end, span_color, last_span,
		input ready);
	modport sink   (input valid, row, x_start, x_end, span_color, last_span,
		output ready);
endinterface

>>> rtl/core/midpoint_filled_circle_spans.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_filled_circle_spans: filled circle to horizontal spans
// Turns one circle request into the inclusive row spans that cover the disc.
// ----------------------------------------------------------------------------
// Each request (center, radius, color) yields 3 + 4*k spans, where k is the
// number of midpoint walk steps (at most 14 at radius 20, so 59 spans), in
// the order bottom point, top point, center row, then four rows per step.
// The span sequencer emits one span per cycle into a registered output while
// the span sink is ready, and it takes the next request only once it is idle.
// Requests are taken into a clamp stage and a two-entry queue while the
// sequencer is busy, so intake only stalls once both are full. Radii above
// 20 are clamped to 20.
module midpoint_filled_circle_spans (
	input  logic       clk,
	input  logic       arst_n,
	mfcs_req_if.sink   req,
	mfcs_span_if.source span
);
	import mfcs_pkg::*;

	logic        push_valid;
	logic        push_ready;
	circle_req_t push_data;
	logic        pop_valid;
	logic        pop_ready;
	circle_req_t pop_data;

	// request intake and radius clamp
	mfcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decoupling queue
	mfcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// walk and span emission
	mfcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.span      (span)
	);

endmodule

>>> rtl/core/mfcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcs_front: request intake
// Takes circle requests, saturates the radius and hands them to the queue.
// ----------------------------------------------------------------------------
module mfcs_front (
	input  logic                clk,
	input  logic                arst_n,
	mfcs_req_if.sink            req,
	output logic                push_valid,
	input  logic                push_ready,
	output mfcs_pkg::circle_req_t push_data
);
	import mfcs_pkg::*;

	logic        req_s1_valid;
	circle_req_t req_s1;
	logic [RAD_W-1:0] rad_sat;

	// radius clamp
	assign rad_sat = (req.radius > MAX_RADIUS) ? MAX_RADIUS : req.radius;

	// stage accepts when empty or draining into the queue
	assign req.ready = !req_s1_valid || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1_valid <= 1'b0;
		end else if (req.ready) begin
			req_s1_valid <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.center_x <= req.center_x;
			req_s1.center_y <= req.center_y;
			req_s1.radius   <= rad_sat;
			req_s1.color    <= req.color;
		end
	end

	assign push_valid = req_s1_valid;
	assign push_data  = req_s1;

endmodule

>>> rtl/core/mfcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcs_queue: request queue
// Two-entry flop queue decoupling request intake from span generation.
// ----------------------------------------------------------------------------
module mfcs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  mfcs_pkg::circle_req_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output mfcs_pkg::circle_req_t pop_data
);
	import mfcs_pkg::*;

	circle_req_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop)  rptr_q <= rptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= push_data;
	end

endmodule

>>> rtl/core/mfcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcs_back: span sequencer
// Runs the midpoint circle walk for one request and emits one span a cycle while span.ready allows.
// ----------------------------------------------------------------------------
module mfcs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  mfcs_pkg::circle_req_t pop_data,
	mfcs_span_if.source         span
);
	import mfcs_pkg::*;

	// sequencer phases
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_BOT  = 3'd1;
	localparam logic [2:0] PH_TOP  = 3'd2;
	localparam logic [2:0] PH_MID  = 3'd3;
	localparam logic [2:0] PH_W0   = 3'd4;
	localparam logic [2:0] PH_W1   = 3'd5;
	localparam logic [2:0] PH_W2   = 3'd6;
	localparam logic [2:0] PH_W3   = 3'd7;

	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_SPANS - SPANS_PER_STEP);

	logic [2:0]                phase_q;
	logic [COORD_W-1:0]        x0_q;
	logic [COORD_W-1:0]        y0_q;
	logic [COLOR_W-1:0]        color_q;
	logic [RAD_W-1:0]          cx_q;
	logic [RAD_W-1:0]          cy_q;
	logic signed [TERM_W-1:0]  d_q;
	logic signed [TERM_W-1:0]  dx_q;
	logic signed [TERM_W-1:0]  dy_q;
	logic [CNT_W-1:0]          cnt_q;

	logic                      out_valid_q;
	logic signed [SPAN_W-1:0]  row_q;
	logic signed [SPAN_W-1:0]  xs_q;
	logic signed [SPAN_W-1:0]  xe_q;
	logic [COLOR_W-1:0]        ocolor_q;
	logic                      last_q;

	logic                      fire;
	logic                      cont;
	logic                      step_end;
	logic [CNT_W-1:0]          cnt_next;
	logic signed [SPAN_W-1:0]  x0_e, y0_e, cx_e, cy_e;
	logic signed [SPAN_W-1:0]  row_c, xs_c, xe_c;

	assign pop_ready = (phase_q == PH_IDLE);
	assign fire      = (phase_q != PH_IDLE) && (!out_valid_q || span.ready);
	assign cnt_next  = cnt_q + 1'b1;
	assign step_end  = (phase_q == PH_MID) || (phase_q == PH_W3);
	// another walk step only while below the diagonal and the budget has room
	assign cont      = (cx_q < cy_q) && (cnt_next <= CNT_LIMIT);

	assign x0_e = $signed({2'b00, x0_q});
	assign y0_e = $signed({2'b00, y0_q});
	assign cx_e = $signed({7'b0, cx_q});
	assign cy_e = $signed({7'b0, cy_q});

	// span of the current phase
	always_comb begin
		row_c = y0_e;
		xs_c  = x0_e;
		xe_c  = x0_e;
		case (phase_q)
			PH_BOT: row_c = y0_e + cy_e;
			PH_TOP: row_c = y0_e - cy_e;
			PH_MID: begin
				xs_c = x0_e - cy_e;
				xe_c = x0_e + cy_e;
			end
			PH_W0: begin
				row_c = y0_e - cy_e;
				xs_c  = x0_e - cx_e;
				xe_c  = x0_e + cx_e;
			end
			PH_W1: begin
				row_c = y0_e + cy_e;
				xs_c  = x0_e - cx_e;
				xe_c  = x0_e + cx_e;
			end
			PH_W2: begin
				row_c = y0_e - cx_e;
				xs_c  = x0_e - cy_e;
				xe_c  = x0_e + cy_e;
			end
			PH_W3: begin
				row_c = y0_e + cx_e;
				xs_c  = x0_e - cy_e;
				xe_c  = x0_e + cy_e;
			end
			default: row_c = y0_e;
		endcase
	end

	// phase sequencing and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else if (phase_q == PH_IDLE) begin
			if (pop_valid) begin
				phase_q <= PH_BOT;
				cnt_q   <= '0;
			end
		end else if (fire) begin
			cnt_q <= cnt_next;
			case (phase_q)
				PH_BOT:        phase_q <= PH_TOP;
				PH_TOP:        phase_q <= PH_MID;
				PH_W0:         phase_q <= PH_W1;
				PH_W1:         phase_q <= PH_W2;
				PH_W2:         phase_q <= PH_W3;
				PH_MID, PH_W3: phase_q <= cont ? PH_W0 : PH_IDLE;
				default:       phase_q <= PH_IDLE;
			endcase
		end
	end

	// walk terms
	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && pop_valid) begin
			x0_q    <= pop_data.center_x;
			y0_q    <= pop_data.center_y;
			color_q <= pop_data.color;
			cx_q    <= '0;
			cy_q    <= pop_data.radius;
			dx_q    <= TERM_W'(3);
			dy_q    <= $signed(TERM_W'(2)) - $signed({4'b0, pop_data.radius, 1'b0});
			d_q     <= $signed(TERM_W'(1)) - $signed({5'b0, pop_data.radius});
		end else if (fire && step_end && cont) begin
			cx_q <= cx_q + 1'b1;
			dx_q <= dx_q + TERM_W'(2);
			if (d_q < 0) begin
				d_q <= d_q + dx_q;
			end else begin
				d_q  <= d_q + dx_q + dy_q;
				dy_q <= dy_q + TERM_W'(2);
				cy_q <= cy_q - 1'b1;
			end
		end
	end

	// output span register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (span.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			row_q    <= row_c;
			xs_q     <= xs_c;
			xe_q     <= xe_c;
			ocolor_q <= color_q;
			last_q   <= step_end && !cont;
		end
	end

	assign span.valid      = out_valid_q;
	assign span.row        = row_q;
	assign span.x_start    = xs_q;
	assign span.x_end      = xe_q;
	assign span.span_color = ocolor_q;
	assign span.last_span  = last_q;

endmodule
